// ===== hdl/csw_pkg.sv =====
package csw_pkg;

  localparam int CoordW = 8;   // width of a grid coordinate
  localparam int GridW  = 9;   // width of the grid size registers
  localparam int RadW   = 8;   // width of the radius register
  localparam int OffW   = 10;  // signed offset / position width
  localparam int LegW   = 9;   // leg length and leg progress width
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam int CSW_MAX_DIM = 256;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_WALK_RADIUS = 2'd2
  } cfg_reg_t;

  // spiral headings
  typedef enum logic [1:0] {
    HEAD_PCOL = 2'd0,
    HEAD_PROW = 2'd1,
    HEAD_NCOL = 2'd2,
    HEAD_NROW = 2'd3
  } heading_t;

  typedef struct packed {
    logic              restart;
    logic [CoordW-1:0] center_row;
    logic [CoordW-1:0] center_col;
  } req_word_t;

  typedef struct packed {
    logic [CoordW-1:0] cell_row;
    logic [CoordW-1:0] cell_col;
    logic              done_res;
  } res_word_t;

  // spiral walker state, offsets relative to the walk center
  typedef struct packed {
    logic signed [OffW-1:0] off_row;
    logic signed [OffW-1:0] off_col;
    heading_t               heading;
    logic [LegW-1:0]        leg_length;
    logic [LegW-1:0]        leg_progress;
    logic                   second_leg;
  } walk_t;

  typedef struct packed {
    logic hit;     // candidate position is in the grid
    logic beyond;  // candidate position is outside the radius
  } step_flags_t;

endpackage

// ===== hdl/csw_step.sv =====
module csw_step #(
  parameter int MAX_DIM = csw_pkg::CSW_MAX_DIM,
  parameter int CW = ($clog2(MAX_DIM + 1) > csw_pkg::GridW) ?
                     $clog2(MAX_DIM + 1) : csw_pkg::GridW
) (
  input  logic                        restart,
  input  logic [csw_pkg::CoordW-1:0]  center_row,
  input  logic [csw_pkg::CoordW-1:0]  center_col,
  input  logic [csw_pkg::CoordW-1:0]  origin_row,
  input  logic [csw_pkg::CoordW-1:0]  origin_col,
  input  csw_pkg::walk_t              walk,
  input  logic [CW-1:0]               eff_rows,
  input  logic [CW-1:0]               eff_cols,
  input  logic [csw_pkg::RadW-1:0]    radius,
  output csw_pkg::walk_t              walk_next,
  output logic [csw_pkg::CoordW-1:0]  cand_row,
  output logic [csw_pkg::CoordW-1:0]  cand_col,
  output csw_pkg::step_flags_t        flags
);
  import csw_pkg::*;

  walk_t                  adv;
  logic [LegW-1:0]        prog_inc;
  logic signed [OffW-1:0] pos_row;
  logic signed [OffW-1:0] pos_col;
  logic [OffW-1:0]        abs_row;
  logic [OffW-1:0]        abs_col;

  // one spiral step
  always_comb begin
    adv = walk;
    case (walk.heading)
      HEAD_PCOL: adv.off_col = walk.off_col + OffW'(1);
      HEAD_PROW: adv.off_row = walk.off_row + OffW'(1);
      HEAD_NCOL: adv.off_col = walk.off_col - OffW'(1);
      HEAD_NROW: adv.off_row = walk.off_row - OffW'(1);
      default:   adv.off_col = walk.off_col;
    endcase
    prog_inc = walk.leg_progress + LegW'(1);
    adv.leg_progress = prog_inc;
    if (prog_inc >= walk.leg_length) begin
      adv.leg_progress = '0;
      adv.heading      = heading_t'(walk.heading + 2'd1);
      if (walk.second_leg) begin
        adv.leg_length = walk.leg_length + LegW'(1);
        adv.second_leg = 1'b0;
      end else begin
        adv.second_leg = 1'b1;
      end
    end
  end

  always_comb begin
    if (restart) begin
      walk_next = '{off_row: '0, off_col: '0, heading: HEAD_PCOL,
                    leg_length: LegW'(1), leg_progress: '0, second_leg: 1'b0};
      pos_row = $signed({2'b00, center_row});
      pos_col = $signed({2'b00, center_col});
    end else begin
      walk_next = adv;
      pos_row = $signed({2'b00, origin_row}) + adv.off_row;
      pos_col = $signed({2'b00, origin_col}) + adv.off_col;
    end
  end

  assign abs_row = walk_next.off_row[OffW-1] ? OffW'(-walk_next.off_row)
                                             : OffW'(walk_next.off_row);
  assign abs_col = walk_next.off_col[OffW-1] ? OffW'(-walk_next.off_col)
                                             : OffW'(walk_next.off_col);

  assign flags.beyond = (abs_row > OffW'(radius)) || (abs_col > OffW'(radius));
  assign flags.hit    = !pos_row[OffW-1] && !pos_col[OffW-1] &&
                        (CW'(pos_row[OffW-2:0]) < eff_rows) &&
                        (CW'(pos_col[OffW-2:0]) < eff_cols);

  assign cand_row = pos_row[CoordW-1:0];
  assign cand_col = pos_col[CoordW-1:0];

endmodule

// ===== hdl/clipped_spiral_coordinate_walker_core.sv =====
// Square-spiral coordinate walker, clipped to a configurable grid.
// Request channel (req_valid/req_ready/req_word): a word with restart set
// starts a new walk at center_row/center_col; a word with restart clear asks
// for the next in-grid cell of the current walk. Every request word gives
// exactly one result word on res_valid/res_ready/res_word: a cell, or
// done_res with zero coordinates when the walk is over, inactive, or the
// center lies outside the grid.
// Config port (cfg_we/cfg_index/cfg_data): grid rows, grid cols and walk
// radius; write only while no request is in flight.
// Flow: a restart, or a request on an inactive walk, is resolved in ST_RUN
// without a spiral step, and its result word is registered. A next request
// steps the spiral in ST_RUN up to the next in-grid cell or the radius exit,
// one step per cycle through the shared step unit, and then its result word
// is registered; where the spiral runs outside the grid it takes more steps.
// One request is worked on at a time; req_ready is high only when idle.
// A finished result sits in the output register; if the receiver stalls the
// next request is still taken and worked, and its result waits in a holding
// register until the output register frees up.
// Reset (rst, synchronous): registers go to 256 rows, 256 cols, radius 1;
// no walk is active and the output register is empty.
module clipped_spiral_coordinate_walker_core #(
  parameter int MAX_DIM = csw_pkg::CSW_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  csw_pkg::req_word_t            req_word,
  output logic                          res_valid,
  input  logic                          res_ready,
  output csw_pkg::res_word_t            res_word,
  input  logic                          cfg_we,
  input  logic [csw_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [csw_pkg::CfgDataW-1:0]  cfg_data
);
  import csw_pkg::*;

  localparam int EffW = $clog2(MAX_DIM + 1);
  localparam int CW   = (EffW > GridW) ? EffW : GridW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // config registers
  logic [GridW-1:0] grid_rows;
  logic [GridW-1:0] grid_cols;
  logic [RadW-1:0]  walk_radius;
  logic [CW-1:0]    eff_rows;
  logic [CW-1:0]    eff_cols;

  // walker state
  req_word_t          req;
  logic               walk_active;
  logic [CoordW-1:0]  origin_row;
  logic [CoordW-1:0]  origin_col;
  walk_t              walk;
  walk_t              walk_next;
  logic [CoordW-1:0]  cand_row;
  logic [CoordW-1:0]  cand_col;
  step_flags_t        flags;

  // result path
  res_word_t pend;
  res_word_t result;
  logic      finish;
  logic      slot_free;
  logic      load_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows   <= GridW'(256);
      grid_cols   <= GridW'(256);
      walk_radius <= RadW'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_ROWS:   grid_rows   <= cfg_data[GridW-1:0];
        REG_GRID_COLS:   grid_cols   <= cfg_data[GridW-1:0];
        REG_WALK_RADIUS: walk_radius <= cfg_data[RadW-1:0];
        default: ;
      endcase
    end
  end

  // grid sizes above MAX_DIM act as MAX_DIM
  assign eff_rows = (CW'(grid_rows) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(grid_rows);
  assign eff_cols = (CW'(grid_cols) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(grid_cols);

  csw_step #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW)
  ) u_step (
    .restart    (req.restart),
    .center_row (req.center_row),
    .center_col (req.center_col),
    .origin_row (origin_row),
    .origin_col (origin_col),
    .walk       (walk),
    .eff_rows   (eff_rows),
    .eff_cols   (eff_cols),
    .radius     (walk_radius),
    .walk_next  (walk_next),
    .cand_row   (cand_row),
    .cand_col   (cand_col),
    .flags      (flags)
  );

  assign req_ready = (state == ST_IDLE);
  assign slot_free = !res_valid || res_ready;

  // resolve this cycle's step: finish says a result word is ready
  always_comb begin
    finish = 1'b0;
    result = '{cell_row: '0, cell_col: '0, done_res: 1'b1};
    if (state == ST_RUN) begin
      if (req.restart) begin
        finish = 1'b1;
        if (flags.hit) begin
          result = '{cell_row: cand_row, cell_col: cand_col, done_res: 1'b0};
        end
      end else if (!walk_active || flags.beyond) begin
        finish = 1'b1;
      end else if (flags.hit) begin
        finish = 1'b1;
        result = '{cell_row: cand_row, cell_col: cand_col, done_res: 1'b0};
      end
    end
  end

  always_comb begin
    state_next = state;
    load_res   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (finish) begin
          if (slot_free) begin
            load_res   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_word <= (state == ST_HOLD) ? pend : result;
    end
    if (state == ST_RUN && finish) begin
      pend <= result;
    end
    if (req_valid && req_ready) begin
      req <= req_word;
    end
  end

  // walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
      origin_row  <= '0;
      origin_col  <= '0;
      walk        <= '{off_row: '0, off_col: '0, heading: HEAD_PCOL,
                       leg_length: LegW'(1), leg_progress: '0, second_leg: 1'b0};
    end else if (state == ST_RUN) begin
      if (req.restart) begin
        origin_row  <= req.center_row;
        origin_col  <= req.center_col;
        walk        <= walk_next;
        walk_active <= flags.hit;
      end else if (walk_active) begin
        walk <= walk_next;
        if (flags.beyond) begin
          walk_active <= 1'b0;
        end
      end
    end
  end

endmodule
